[design/stpe_pkg.sv]
// shared types, codes and constants for the slow tape pulse encoder
package stpe_pkg;

   // field widths
   localparam int unsigned ByteW = 8;
   localparam int unsigned ModeW = 2;
   localparam int unsigned CsrIndexW = 2;

   // runs per byte: two half pulses for each of eight bits
   localparam int unsigned RunsPerByte = 16;
   localparam int unsigned StepW = $clog2(RunsPerByte);
   localparam logic [StepW-1:0] LastStep = StepW'(RunsPerByte - 1);

   // byte queue between front and back
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueuePtrW = $clog2(QueueDepth);
   localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

   // input modes
   localparam logic [ModeW-1:0] MODE_PLAIN = 2'd0;
   localparam logic [ModeW-1:0] MODE_SUMMED = 2'd1;
   localparam logic [ModeW-1:0] MODE_CHECK = 2'd2;

   // register indexes
   localparam logic [CsrIndexW-1:0] CSR_ONE_RUN = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_ZERO_RUN = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_HIGH_LEVEL = 2'd2;
   localparam logic [CsrIndexW-1:0] CSR_LOW_LEVEL = 2'd3;

   // register reset values
   localparam logic [ByteW-1:0] RESET_ONE_RUN = 8'd13;
   localparam logic [ByteW-1:0] RESET_ZERO_RUN = 8'd39;
   localparam logic [ByteW-1:0] RESET_HIGH_LEVEL = 8'hff;
   localparam logic [ByteW-1:0] RESET_LOW_LEVEL = 8'h00;

   // one byte moving through the queue
   typedef struct packed {
      logic             valid;
      logic [ByteW-1:0] data;
   } byte_beat_type;

   // one run on the output side
   typedef struct packed {
      logic             last;
      logic [ByteW-1:0] run_length;
      logic [ByteW-1:0] level;
   } run_type;

endpackage

[design/slow_tape_pulse_encoder.sv]
// top level of the slow tape pulse encoder
// Each byte taken on req_ becomes sixteen runs on rsp_, most significant bit
// first: per bit a run at high_level then one at low_level, both of
// one_run_length for a 1 and zero_run_length for a 0; rsp_tlast marks the
// sixteenth run. The run generator issues one run per cycle from its output
// register while rsp_tready holds high, and bytes follow with no gap; a
// two-byte queue holds the byte whose runs are being sent and one more, so the
// next byte is taken while the current one is still running out. Mode 1 adds
// the byte to an 8-bit wrapping sum, mode 2 sends that sum and clears it,
// modes 0 and 3 send the byte alone. Write the csr_ registers only while no
// runs are pending.
module slow_tape_pulse_encoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // data_byte [7:0]
   input  logic [stpe_pkg::ByteW-1:0]     req_tdata,
   // mode [1:0]
   input  logic [stpe_pkg::ModeW-1:0]     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // level [7:0], run_length [15:8]
   output logic [2*stpe_pkg::ByteW-1:0]   rsp_tdata,
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [stpe_pkg::CsrIndexW-1:0] csr_index,
   input  logic [stpe_pkg::ByteW-1:0]     csr_data
);
   import stpe_pkg::*;

   byte_beat_type push;
   byte_beat_type head;
   logic          queue_full;
   logic          pop;
   run_type       rsp_run;

   stpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .queue_full (queue_full)
   );

   stpe_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   stpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_run    (rsp_run)
   );

   // output beat packing
   assign rsp_tdata = {rsp_run.run_length, rsp_run.level};
   assign rsp_tlast = rsp_run.last;

endmodule

[design/stpe_front.sv]
// front end: takes input beats, resolves the mode and keeps the running sum
module stpe_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [stpe_pkg::ByteW-1:0]  req_tdata,
   input  logic [stpe_pkg::ModeW-1:0]  req_tuser,
   output stpe_pkg::byte_beat_type     push,
   input  logic                        queue_full
);
   import stpe_pkg::*;

   logic [ByteW-1:0] sum_ff;
   logic [ByteW-1:0] sum_in;
   logic [ByteW-1:0] send_byte;
   logic             accept;

   assign req_tready = !queue_full;
   assign accept = req_tvalid && req_tready;

   // pick the byte to send and the next sum
   always_comb begin
      send_byte = req_tdata;
      sum_in = sum_ff;
      case (req_tuser)
         MODE_SUMMED: begin
            sum_in = sum_ff + req_tdata;
         end
         MODE_CHECK: begin
            send_byte = sum_ff;
            sum_in = '0;
         end
         default: begin
            sum_in = sum_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (accept) begin
         sum_ff <= sum_in;
      end
   end

   assign push.valid = req_tvalid;
   assign push.data = send_byte;

endmodule

[design/stpe_queue.sv]
// short byte queue between the front end and the run generator
module stpe_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  stpe_pkg::byte_beat_type push,
   output logic                    full,
   output stpe_pkg::byte_beat_type head,
   input  logic                    pop
);
   import stpe_pkg::*;

   logic [ByteW-1:0]     mem_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff;
   logic [QueuePtrW-1:0] wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff;
   logic [QueuePtrW-1:0] rd_ptr_in;
   logic [QueueCntW-1:0] count_ff;
   logic [QueueCntW-1:0] count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full = (count_ff == QueueCntW'(QueueDepth));
   assign do_push = push.valid && !full;
   assign do_pop = pop && head.valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.data;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.data = mem_ff[rd_ptr_ff];

endmodule

[design/stpe_back.sv]
// back end: holds the run registers and turns each byte into sixteen runs
module stpe_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [stpe_pkg::CsrIndexW-1:0] csr_index,
   input  logic [stpe_pkg::ByteW-1:0]     csr_data,
   input  stpe_pkg::byte_beat_type        head,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output stpe_pkg::run_type              rsp_run
);
   import stpe_pkg::*;

   logic [ByteW-1:0] one_run_ff;
   logic [ByteW-1:0] zero_run_ff;
   logic [ByteW-1:0] high_level_ff;
   logic [ByteW-1:0] low_level_ff;
   logic [StepW-1:0] step_ff;
   logic             out_valid_ff;
   logic             out_valid_in;
   run_type          out_run_ff;
   run_type          out_run_in;
   logic             load;
   logic             bit_value;
   logic [2:0]       bit_sel;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         one_run_ff <= RESET_ONE_RUN;
         zero_run_ff <= RESET_ZERO_RUN;
         high_level_ff <= RESET_HIGH_LEVEL;
         low_level_ff <= RESET_LOW_LEVEL;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ONE_RUN:    one_run_ff <= csr_data;
            CSR_ZERO_RUN:   zero_run_ff <= csr_data;
            CSR_HIGH_LEVEL: high_level_ff <= csr_data;
            CSR_LOW_LEVEL:  low_level_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // a run loads when a byte waits and the output register is free
   assign load = head.valid && (!out_valid_ff || rsp_tready);
   assign pop = load && (step_ff == LastStep);

   // msb first: bit index counts down with each pair of runs
   assign bit_sel = 3'd7 - step_ff[StepW-1:1];
   assign bit_value = head.data[bit_sel];

   always_comb begin
      out_run_in.level = step_ff[0] ? low_level_ff : high_level_ff;
      out_run_in.run_length = bit_value ? one_run_ff : zero_run_ff;
      out_run_in.last = (step_ff == LastStep);
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // step counter and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (load) begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         out_run_ff <= out_run_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_run = out_run_ff;

endmodule

[tb/stpe_run_checker.sv]
// run checker for the slow tape pulse encoder: predicts each byte's runs and compares rsp beats
module stpe_run_checker
   import stpe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [ByteW-1:0]       req_tdata,
   input  logic [ModeW-1:0]       req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [2*ByteW-1:0]     rsp_tdata,
   input  logic                   rsp_tlast,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CsrIndexW-1:0]   csr_index,
   input  logic [ByteW-1:0]       csr_data,
   output int                     runs_pending,
   output int                     fail_count
);

   // shadow copy of the registers and the block check sum
   logic [ByteW-1:0] one_len;
   logic [ByteW-1:0] zero_len;
   logic [ByteW-1:0] high_lvl;
   logic [ByteW-1:0] low_lvl;
   logic [ByteW-1:0] check_sum;

   // runs still owed by the block, oldest first
   run_type expected_runs[$];

   // turn one accepted byte into its sixteen runs, msb first
   function automatic void expand_byte(input logic [ModeW-1:0] mode,
                                       input logic [ByteW-1:0] data);
      logic [ByteW-1:0] sent;
      logic [ByteW-1:0] len;
      run_type          run;
      int               b;
      sent = data;
      if (mode == MODE_CHECK) begin
         sent = check_sum;
         check_sum = '0;
      end else if (mode == MODE_SUMMED) begin
         check_sum = check_sum + data;
      end
      for (b = ByteW - 1; b >= 0; b--) begin
         len = sent[b] ? one_len : zero_len;
         run.run_length = len;
         run.level = high_lvl;
         run.last = 1'b0;
         expected_runs.push_back(run);
         run.level = low_lvl;
         run.last = (b == 0);
         expected_runs.push_back(run);
      end
   endfunction

   // compare rsp beats, track register writes, predict accepted bytes
   always @(posedge clock) begin
      run_type want;
      if (reset) begin
         one_len = RESET_ONE_RUN;
         zero_len = RESET_ZERO_RUN;
         high_lvl = RESET_HIGH_LEVEL;
         low_lvl = RESET_LOW_LEVEL;
         check_sum = '0;
         expected_runs.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_runs.size() == 0) begin
               fail_count++;
               $error("rsp beat with no run expected: tdata %0h tlast %0b",
                      rsp_tdata, rsp_tlast);
            end else begin
               want = expected_runs.pop_front();
               if (rsp_tdata[ByteW-1:0] !== want.level) begin
                  fail_count++;
                  $error("level mismatch: expected %0h, actual %0h",
                         want.level, rsp_tdata[ByteW-1:0]);
               end
               if (rsp_tdata[2*ByteW-1:ByteW] !== want.run_length) begin
                  fail_count++;
                  $error("run_length mismatch: expected %0d, actual %0d",
                         want.run_length, rsp_tdata[2*ByteW-1:ByteW]);
               end
               if (rsp_tlast !== want.last) begin
                  fail_count++;
                  $error("last_of_byte mismatch: expected %0b, actual %0b",
                         want.last, rsp_tlast);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ONE_RUN:    one_len = csr_data;
               CSR_ZERO_RUN:   zero_len = csr_data;
               CSR_HIGH_LEVEL: high_lvl = csr_data;
               CSR_LOW_LEVEL:  low_lvl = csr_data;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expand_byte(req_tuser, req_tdata);
         end
      end
      runs_pending = expected_runs.size();
   end

endmodule

[tb/tb_top.sv]
// testbench top for the slow tape pulse encoder: clock, reset, stimulus and verdict
module tb_top;
   import stpe_pkg::*;

   // the fourth mode code has no name in the package and behaves as plain
   localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;
   localparam int CycleLimit = 400000;
   localparam int LongHold = 300;
   localparam int SettleCycles = 40;
   localparam int Phases = 8;
   localparam int PhaseItems = 60;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ByteW-1:0]     req_tdata = '0;
   logic [ModeW-1:0]     req_tuser = MODE_PLAIN;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [2*ByteW-1:0]   rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CsrIndexW-1:0] csr_index = CSR_ONE_RUN;
   logic [ByteW-1:0]     csr_data = '0;

   int runs_pending;
   int fail_count;
   int cycle_count = 0;
   bit no_idle = 1'b0;
   int hold_requests = 0;

   always #5 clock = ~clock;

   slow_tape_pulse_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   stpe_run_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .runs_pending (runs_pending),
      .fail_count   (fail_count)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // one req beat after a random gap
   task automatic send_byte(input logic [ModeW-1:0] mode, input logic [ByteW-1:0] data);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and wait until every run has come out
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (runs_pending != 0) @(negedge clock);
   endtask

   // one register write beat
   task automatic csr_write(input logic [CsrIndexW-1:0] index, input logic [ByteW-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // register value leaning toward the extremes, zero run length included
   function automatic logic [ByteW-1:0] pick_reg_value();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'h01;
         2:       return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [ByteW-1:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // stimulus
   initial begin
      int p;
      int sent;
      int k;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, every mode, sum wrap, check of an empty sum
      send_byte(MODE_PLAIN, 8'h00);
      send_byte(MODE_PLAIN, 8'hff);
      send_byte(MODE_PLAIN, 8'h80);
      send_byte(MODE_PLAIN, 8'h01);
      send_byte(MODE_PLAIN, 8'ha5);
      send_byte(MODE_SUMMED, 8'hff);
      send_byte(MODE_SUMMED, 8'h01);
      send_byte(MODE_SUMMED, 8'h80);
      send_byte(MODE_SUMMED, 8'h7f);
      send_byte(MODE_CHECK, 8'h00);
      send_byte(MODE_CHECK, 8'hff);
      send_byte(MODE_SPARE, 8'h5a);
      send_byte(MODE_SUMMED, 8'h3c);
      send_byte(MODE_CHECK, 8'hc3);

      // directed: extreme lengths and swapped levels
      drain();
      csr_write(CSR_ONE_RUN, 8'h01);
      csr_write(CSR_ZERO_RUN, 8'hff);
      csr_write(CSR_HIGH_LEVEL, 8'h00);
      csr_write(CSR_LOW_LEVEL, 8'hff);
      send_byte(MODE_PLAIN, 8'h0f);
      send_byte(MODE_SUMMED, 8'hf0);
      send_byte(MODE_CHECK, 8'h00);

      // directed: run lengths written as zero
      drain();
      csr_write(CSR_ONE_RUN, 8'h00);
      csr_write(CSR_ZERO_RUN, 8'h00);
      csr_write(CSR_HIGH_LEVEL, 8'hff);
      csr_write(CSR_LOW_LEVEL, 8'h00);
      send_byte(MODE_PLAIN, 8'h55);
      send_byte(MODE_SPARE, 8'haa);

      drain();
      csr_write(CSR_ONE_RUN, 8'hff);
      csr_write(CSR_ZERO_RUN, 8'h01);
      csr_write(CSR_HIGH_LEVEL, 8'h80);
      csr_write(CSR_LOW_LEVEL, 8'h7f);
      send_byte(MODE_PLAIN, 8'hc3);

      // random phases: mostly sync, summed block, check byte; some noise
      for (p = 0; p < Phases; p++) begin
         drain();
         csr_write(CSR_ONE_RUN, pick_reg_value());
         csr_write(CSR_ZERO_RUN, pick_reg_value());
         csr_write(CSR_HIGH_LEVEL, pick_reg_value());
         csr_write(CSR_LOW_LEVEL, pick_reg_value());
         no_idle = (p == 2) || (p == 4);
         if (p == 4) begin
            hold_requests = hold_requests + 1;
         end
         sent = 0;
         while (sent < PhaseItems) begin
            if ($urandom_range(0, 4) == 0) begin
               send_byte(2'($urandom_range(0, 3)), pick_byte());
               sent++;
            end else begin
               send_byte(MODE_PLAIN, pick_byte());
               k = $urandom_range(1, 8);
               repeat (k) send_byte(MODE_SUMMED, pick_byte());
               send_byte(MODE_CHECK, pick_byte());
               sent += k + 2;
            end
         end
      end
      no_idle = 1'b0;

      // wrap up
      drain();
      repeat (SettleCycles) @(negedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // receiver: random stalls per beat, one long hold when asked
   initial begin
      int stall;
      int holds_done;
      holds_done = 0;
      forever begin
         if (hold_requests > holds_done) begin
            holds_done++;
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (LongHold) @(negedge clock);
         end
         stall = no_idle ? 0 : $urandom_range(0, 4);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

endmodule

[files.f]
design/stpe_pkg.sv
design/stpe_front.sv
design/stpe_queue.sv
design/stpe_back.sv
design/slow_tape_pulse_encoder.sv
tb/stpe_run_checker.sv
tb/tb_top.sv
